### hdl/fpba_pkg.sv
// Shared types and codes for the fit-policy block allocator.
// Used by fpba_fit_unit, fit_policy_block_allocator and its testbench; depends on nothing.
`timescale 1ns / 1ps

package fpba_pkg;

    localparam int FUNC_W = 2;
    localparam int SLOT_W = 4;
    localparam int VALUE_W = 16;
    localparam int MODE_W = 2;
    localparam int COUNT_W = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_INDEX_W = 1;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic qualify;
        logic take;
    } fit_flags_t;

endpackage

### hdl/fpba_fit_unit.sv
// Shared compare unit that judges one candidate block against the request.
// Depends on fpba_pkg for the mode codes and the flag struct.
`timescale 1ns / 1ps

module fpba_fit_unit
    import fpba_pkg::*;
#(
    parameter int SIZE_BITS = 16
)
(
    input  logic [MODE_W-1:0]    fit_mode,
    input  logic                 found,
    input  logic                 used,
    input  logic [SIZE_BITS-1:0] cand_size,
    input  logic [SIZE_BITS-1:0] req_size,
    input  logic [SIZE_BITS-1:0] pick_left,
    output logic [SIZE_BITS-1:0] left,
    output fit_flags_t           flags
);

    logic [SIZE_BITS:0] diff;
    logic               better;

    always_comb
    begin
        diff = {1'b0, cand_size} - {1'b0, req_size};
        left = diff[SIZE_BITS-1:0];
        flags.qualify = !used && !diff[SIZE_BITS];
        case (fit_mode)
            MODE_BEST:  better = left < pick_left;
            MODE_WORST: better = left > pick_left;
            default:    better = 1'b0;
        endcase
        flags.take = flags.qualify && (!found || better);
    end

endmodule

### hdl/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator: size table, used marks and scan sequencer.
// Depends on fpba_pkg and instantiates fpba_fit_unit.
`timescale 1ns / 1ps

// Load and clear items are carried out as they are accepted. A request item walks the
// table one slot per cycle through a single shared compare unit over the first N slots,
// where N is block_count saturated to NUM_BLOCKS; the next item is accepted once the
// result has moved into the output register. The size table is a memory with one write
// port and one registered read port, read in slot order.
module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FUNC_W-1:0]      func,
    input  logic [SLOT_W-1:0]      slot_index,
    input  logic [VALUE_W-1:0]     size_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   granted,
    output logic [SLOT_W-1:0]      chosen_index,
    output logic [VALUE_W-1:0]     chosen_size
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    logic [SIZE_BITS-1:0]  size_mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]  rd_data_reg;

    state_t                state_reg, state_next;
    logic [MODE_W-1:0]     fit_mode_reg;
    logic [COUNT_W-1:0]    block_count_reg;
    logic [NUM_BLOCKS-1:0] used_reg, used_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [SIZE_BITS-1:0]  req_reg, req_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_idx_reg, pick_idx_next;
    logic [SIZE_BITS-1:0]  pick_left_reg, pick_left_next;
    logic [SIZE_BITS-1:0]  pick_size_reg, pick_size_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  granted_reg, granted_next;
    logic [SLOT_W-1:0]     out_idx_reg, out_idx_next;
    logic [VALUE_W-1:0]    out_size_reg, out_size_next;

    logic                  in_fire;
    logic [CNT_W-1:0]      limit;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  load_out;
    logic [SIZE_BITS-1:0]  cand_left;
    fit_flags_t            cand_flags;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign limit = (32'(block_count_reg) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                      : CNT_W'(block_count_reg);
    assign mem_we = in_fire && (func == FUNC_LOAD) && (32'(slot_index) < NUM_BLOCKS);
    assign mem_waddr = IDX_W'(slot_index);
    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    assign out_valid = out_valid_reg;
    assign granted = granted_reg;
    assign chosen_index = out_idx_reg;
    assign chosen_size = out_size_reg;

    fpba_fit_unit #(
        .SIZE_BITS(SIZE_BITS)
    ) u_fit (
        .fit_mode (fit_mode_reg),
        .found    (found_reg),
        .used     (used_reg[cmp_idx_reg]),
        .cand_size(rd_data_reg),
        .req_size (req_reg),
        .pick_left(pick_left_reg),
        .left     (cand_left),
        .flags    (cand_flags)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[mem_waddr] <= SIZE_BITS'(size_value);
        end
        if (rd_en)
        begin
            rd_data_reg <= size_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= MODE_FIRST;
            block_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FIT_MODE:    fit_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            scan_cnt_reg <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            scan_cnt_reg <= scan_cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        req_reg <= req_next;
        pick_idx_reg <= pick_idx_next;
        pick_left_reg <= pick_left_next;
        pick_size_reg <= pick_size_next;
        granted_reg <= granted_next;
        out_idx_reg <= out_idx_next;
        out_size_reg <= out_size_next;
    end

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        req_next = req_reg;
        found_next = found_reg;
        pick_idx_next = pick_idx_reg;
        pick_left_next = pick_left_reg;
        pick_size_next = pick_size_reg;
        out_valid_next = out_valid_reg && !out_ready;
        granted_next = granted_reg;
        out_idx_next = out_idx_reg;
        out_size_next = out_size_reg;
        rd_en = 1'b0;
        load_out = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (func)
                        FUNC_REQUEST:
                        begin
                            req_next = SIZE_BITS'(size_value);
                            scan_cnt_next = '0;
                            found_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        FUNC_CLEAR: used_next = '0;
                        default:    ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cmp_vld_reg && cand_flags.take)
                begin
                    found_next = 1'b1;
                    pick_idx_next = cmp_idx_reg;
                    pick_left_next = cand_left;
                    pick_size_next = rd_data_reg;
                end
                if (scan_cnt_reg < limit)
                begin
                    rd_en = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_addr;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    out_valid_next = 1'b1;
                    granted_next = found_reg;
                    out_idx_next = found_reg ? SLOT_W'(pick_idx_reg) : '0;
                    out_size_next = found_reg ? VALUE_W'(pick_size_reg) : '0;
                    if (found_reg)
                    begin
                        used_next[pick_idx_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= limit))
        else $error("Scan counter ran past the active slot count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && load_out && found_reg) |=> used_reg[$past(pick_idx_reg)])
        else $error("Granted block was not marked used.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !granted_reg) |-> (out_idx_reg == '0 && out_size_reg == '0))
        else $error("Refused request carries a nonzero slot or size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && found_reg) |-> (32'(pick_idx_reg) < 32'(limit)))
        else $error("Picked slot lies outside the active slots.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cmp_vld_reg && cand_flags.take)
            |=> (found_reg && pick_size_reg >= req_reg))
        else $error("Picked block is smaller than the request.");

endmodule

### dv/tb_fit_policy_block_allocator.sv
// Self-checking testbench for fit_policy_block_allocator: directed and random load,
// request and clear items under every fit mode, checked against an in-bench allocator.
// Depends on fpba_pkg and the fit_policy_block_allocator RTL.
`timescale 1ns / 1ps

module tb_fit_policy_block_allocator;
    import fpba_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int GAP_PCT = 27;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int TARGET_ITEMS = 1800;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  op;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
    } alloc_op_t;

    typedef struct packed {
        logic               grant;
        logic [SLOT_W-1:0]  index;
        logic [VALUE_W-1:0] size;
    } grant_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_FIT_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func = FUNC_LOAD;
    logic [SLOT_W-1:0]      slot_index = '0;
    logic [VALUE_W-1:0]     size_value = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   granted;
    logic [SLOT_W-1:0]      chosen_index;
    logic [VALUE_W-1:0]     chosen_size;

    // In-bench allocator state and the settings it runs with.
    logic [VALUE_W-1:0]     table_sizes [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   table_used = '0;
    logic [MODE_W-1:0]      cur_mode = MODE_FIRST;
    logic [COUNT_W-1:0]     cur_count = '0;

    alloc_op_t              pending_ops [$];
    grant_t                 grants_due [$];
    logic [VALUE_W-1:0]     gen_sizes [NUM_SLOTS];

    alloc_op_t              next_op;
    grant_t                 seen_grant;
    grant_t                 want_grant;
    bit                     calm = 1'b0;
    int                     errors = 0;
    int                     ops_generated = 0;
    int                     ops_accepted = 0;
    int                     results_seen = 0;
    int                     grants_seen = 0;
    int                     refusals_seen = 0;
    int                     settings_used = 0;
    int                     hold_left = 0;
    int                     holds_done = 0;

    fit_policy_block_allocator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .slot_index   (slot_index),
        .size_value   (size_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .chosen_index (chosen_index),
        .chosen_size  (chosen_size)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic track_allocation(input alloc_op_t op_in);
        int            limit;
        bit            found;
        int            pick;
        logic [VALUE_W-1:0] pick_left;
        logic [VALUE_W-1:0] left;
        grant_t        res;
        limit = (cur_count > NUM_SLOTS) ? NUM_SLOTS : int'(cur_count);
        found = 1'b0;
        pick = 0;
        pick_left = '0;
        case (op_in.op)
            FUNC_LOAD:
                table_sizes[op_in.slot] = op_in.value;
            FUNC_CLEAR:
                table_used = '0;
            FUNC_REQUEST:
            begin
                for (int j = 0; j < limit; j++)
                begin
                    if (!table_used[j] && table_sizes[j] >= op_in.value)
                    begin
                        left = table_sizes[j] - op_in.value;
                        if (!found)
                        begin
                            found = 1'b1;
                            pick = j;
                            pick_left = left;
                            if (cur_mode != MODE_BEST && cur_mode != MODE_WORST)
                                break;
                        end
                        else if (cur_mode == MODE_BEST && left < pick_left)
                        begin
                            pick = j;
                            pick_left = left;
                        end
                        else if (cur_mode == MODE_WORST && left > pick_left)
                        begin
                            pick = j;
                            pick_left = left;
                        end
                    end
                end
                if (found)
                begin
                    table_used[pick] = 1'b1;
                    res.grant = 1'b1;
                    res.index = SLOT_W'(pick);
                    res.size = table_sizes[pick];
                end
                else
                    res = '0;
                grants_due.push_back(res);
            end
            default:
                ;
        endcase
    endtask

    // Sender: offers the queued items, with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FUNC_LOAD;
            slot_index <= '0;
            size_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_allocation({func, slot_index, size_value});
                ops_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= GAP_PCT))
                begin
                    next_op = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    func <= next_op.op;
                    slot_index <= next_op.slot;
                    size_value <= next_op.value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result and stalls at random, with long hold-offs twice.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_grant = {granted, chosen_index, chosen_size};
                results_seen++;
                if (seen_grant.grant)
                    grants_seen++;
                else
                    refusals_seen++;
                if (grants_due.size() == 0)
                begin
                    $error("Result arrived with no request outstanding.");
                    errors++;
                end
                else
                begin
                    want_grant = grants_due.pop_front();
                    if (seen_grant.grant !== want_grant.grant)
                    begin
                        $error("granted: expected %0d, actual %0d",
                               want_grant.grant, seen_grant.grant);
                        errors++;
                    end
                    if (seen_grant.index !== want_grant.index)
                    begin
                        $error("chosen_index: expected %0d, actual %0d",
                               want_grant.index, seen_grant.index);
                        errors++;
                    end
                    if (seen_grant.size !== want_grant.size)
                    begin
                        $error("chosen_size: expected %0d, actual %0d",
                               want_grant.size, seen_grant.size);
                        errors++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (holds_done < 2 && results_seen >= 250 * (holds_done + 1))
            begin
                out_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    task automatic push_op(input logic [FUNC_W-1:0] op, input int slot, input int value);
        alloc_op_t item;
        item.op = op;
        item.slot = SLOT_W'(slot);
        item.value = VALUE_W'(value);
        if (op == FUNC_LOAD)
            gen_sizes[item.slot] = item.value;
        pending_ops.push_back(item);
        ops_generated++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || grants_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(input int mode, input int count);
        wait_idle();
        write_reg(CFG_FIT_MODE, mode);
        write_reg(CFG_BLOCK_COUNT, count);
        cur_mode = MODE_W'(mode);
        cur_count = COUNT_W'(count);
        settings_used++;
    endtask

    function automatic int pick_request_size();
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            base = gen_sizes[$urandom_range(0, NUM_SLOTS - 1)];
            base = base - int'($urandom_range(0, 2));
            return (base < 0) ? 0 : base;
        end
        else if (r < 70)
            return $urandom_range(0, 9000);
        else if (r < 90)
            return $urandom_range(0, 65535);
        else
            return ($urandom_range(0, 1) != 0) ? 65535 : 0;
    endfunction

    function automatic int pick_load_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 65535);
        else if (r < 80)
            return $urandom_range(1, 8) * 1000;
        else
            return $urandom_range(0, 255);
    endfunction

    task automatic random_phase();
        int mode;
        int count;
        int len;
        int r;
        mode = $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 10)
            count = 0;
        else if (r < 20)
            count = $urandom_range(17, 31);
        else
            count = $urandom_range(1, 16);
        apply_settings(mode, count);
        if ($urandom_range(0, 99) < 60)
            push_op(FUNC_CLEAR, $urandom_range(0, 15), $urandom_range(0, 65535));
        len = $urandom_range(40, 120);
        for (int k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 18)
                push_op(FUNC_LOAD, $urandom_range(0, 15), pick_load_size());
            else if (r < 83)
                push_op(FUNC_REQUEST, $urandom_range(0, 15), pick_request_size());
            else if (r < 95)
                push_op(FUNC_CLEAR, $urandom_range(0, 15), $urandom_range(0, 65535));
            else
                push_op(FUNC_RESERVED, $urandom_range(0, 15), $urandom_range(0, 65535));
        end
    endtask

    initial
    begin
        int dir_sizes [NUM_SLOTS];
        int phase_no;
        dir_sizes = '{0, 500, 300, 300, 800, 1200, 1200, 50,
                      2000, 40000, 40000, 700, 100, 9000, 16'h5A5A, 65535};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Every slot gets a size before any search can read it.
        apply_settings(MODE_FIRST, 0);
        for (int s = 0; s < NUM_SLOTS; s++)
            push_op(FUNC_LOAD, s, dir_sizes[s]);
        push_op(FUNC_REQUEST, 0, 1);
        push_op(FUNC_RESERVED, 7, 123);

        apply_settings(MODE_FIRST, 16);
        push_op(FUNC_REQUEST, 3, 0);
        push_op(FUNC_REQUEST, 0, 65535);
        push_op(FUNC_REQUEST, 0, 65535);
        push_op(FUNC_LOAD, 15, 65535);
        push_op(FUNC_REQUEST, 0, 65535);
        push_op(FUNC_REQUEST, 0, 250);
        push_op(FUNC_CLEAR, 0, 0);

        apply_settings(MODE_BEST, 31);
        push_op(FUNC_REQUEST, 0, 250);
        push_op(FUNC_REQUEST, 0, 250);
        push_op(FUNC_REQUEST, 0, 1100);

        apply_settings(MODE_WORST, 16);
        push_op(FUNC_CLEAR, 0, 0);
        push_op(FUNC_REQUEST, 0, 100);
        push_op(FUNC_REQUEST, 0, 100);

        apply_settings(MODE_SPARE, 17);
        push_op(FUNC_CLEAR, 0, 0);
        push_op(FUNC_REQUEST, 0, 400);

        phase_no = 0;
        while (ops_generated < TARGET_ITEMS)
        begin
            random_phase();
            phase_no++;
            calm = (phase_no == 6);
        end

        wait_idle();
        calm = 1'b0;
        if (grants_due.size() != 0)
        begin
            $error("%0d expected results never arrived.", grants_due.size());
            errors++;
        end
        $display("Covered %0d items over %0d mode and count settings.",
                 ops_accepted, settings_used);
        $display("Requests answered: %0d granted, %0d refused; mismatches: %0d.",
                 grants_seen, refusals_seen, errors);
        if (errors == 0)
            $display("PASS fit_policy_block_allocator");
        else
            $display("FAIL fit_policy_block_allocator");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL fit_policy_block_allocator");
        $finish;
    end

endmodule
